FILE: rtl/core/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the 1-Wire bus master
// Command codes, register indexes, reset values, the configuration bundle
// and the classified tick beat passed from front to back.
// ----------------------------------------------------------------------------
package owbm_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned UsW     = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 10;

  // Command codes, equal to the kind field of the input beat
  typedef enum logic [KindW-1:0] {
    CmdNone     = 3'd0,
    CmdReset    = 3'd1,
    CmdWrite    = 3'd2,
    CmdReadByte = 3'd3,
    CmdReadBit  = 3'd4
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgCyclesPerUs    = 3'd0,
    CfgResetLowUs     = 3'd1,
    CfgPresenceWaitUs = 3'd2,
    CfgResetTailUs    = 3'd3,
    CfgWriteOneLowUs  = 3'd4,
    CfgWriteZeroLowUs = 3'd5,
    CfgReadLowUs      = 3'd6,
    CfgReadSampleUs   = 3'd7
  } cfg_idx_e;

  localparam logic [7:0]     RstCyclesPerUs    = 8'd80;
  localparam logic [UsW-1:0] RstResetLowUs     = 10'd500;
  localparam logic [7:0]     RstPresenceWaitUs = 8'd70;
  localparam logic [UsW-1:0] RstResetTailUs    = 10'd430;
  localparam logic [7:0]     RstWriteOneLowUs  = 8'd6;
  localparam logic [7:0]     RstWriteZeroLowUs = 8'd60;
  localparam logic [7:0]     RstReadLowUs      = 8'd4;
  localparam logic [7:0]     RstReadSampleUs   = 8'd8;

  // Fixed slot recovery times
  localparam logic [UsW-1:0] OneRelUs   = 10'd64;
  localparam logic [UsW-1:0] ZeroRelUs  = 10'd10;
  localparam logic [UsW-1:0] ReadRestUs = 10'd52;

  typedef struct packed {
    logic [7:0]     cycles_per_us;
    logic [UsW-1:0] reset_low_us;
    logic [7:0]     presence_wait_us;
    logic [UsW-1:0] reset_tail_us;
    logic [7:0]     write_one_low_us;
    logic [7:0]     write_zero_low_us;
    logic [7:0]     read_low_us;
    logic [7:0]     read_sample_us;
  } cfg_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [ByteW-1:0] tx_byte;
    logic             bus_level;
  } tick_t;

endpackage

FILE: rtl/core/owbm_if.sv
// ----------------------------------------------------------------------------
// owbm_if: channel interfaces of the 1-Wire bus master
// Tick channel into the block and result channel out of it, valid/ready.
// ----------------------------------------------------------------------------
interface owbm_in_if;
  logic                            valid;
  logic                            ready;
  logic [owbm_pkg::KindW-1:0]      kind;
  logic [owbm_pkg::ByteW-1:0]      tx_byte;
  logic                            bus_level;

  modport source (output valid, output kind, output tx_byte, output bus_level,
                  input ready);
  modport sink   (input valid, input kind, input tx_byte, input bus_level,
                  output ready);
endinterface

interface owbm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       drive_low;
  logic                       busy_res;
  logic                       done_res;
  logic                       presence;
  logic [owbm_pkg::ByteW-1:0] rx_data;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output rx_data, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input presence, input rx_data, output ready);
endinterface

FILE: rtl/core/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master: timed 1-Wire bus master
// Each beat on the tick channel is one clock tick of the bus timing engine: it
// carries the sampled line level and, while idle, an optional command (reset
// with presence detect, write byte, read byte, read bit). Each tick yields
// exactly one result beat: drive_low for the open-drain pad, busy, a done
// pulse, presence after a reset and rx_data after a read.
// Throughput: one tick beat per cycle, sustained, as long as the result
// channel takes a beat per cycle. With no stall, an accepted tick beat is
// written into the queue, then the engine step registers its result beat
// into the result register, where it goes valid.
// A two-entry queue sits between the intake and the timing engine, so the
// intake keeps taking ticks while one result waits; when the receiver
// stalls, the queue fills and tick ready drops until it drains.
// Bus phases last whole microseconds; a phase of D us takes D * cycles_per_us
// ticks, counted by the prescaler and phase timer in the engine.
// Configuration writes go straight to the register file; write only while
// the engine is idle. Reset clears the queue, returns the engine to idle and
// loads the default timing registers.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [owbm_pkg::CfgW-1:0]      cfg_wdata_i,
  owbm_in_if.sink                        in_if,
  owbm_out_if.source                     out_if
);

  owbm_pkg::cfg_t  cfg_q;
  owbm_pkg::tick_t push_data, pop_data;
  logic            push, pop, full, empty;

  // Timing register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cycles_per_us     <= owbm_pkg::RstCyclesPerUs;
      cfg_q.reset_low_us      <= owbm_pkg::RstResetLowUs;
      cfg_q.presence_wait_us  <= owbm_pkg::RstPresenceWaitUs;
      cfg_q.reset_tail_us     <= owbm_pkg::RstResetTailUs;
      cfg_q.write_one_low_us  <= owbm_pkg::RstWriteOneLowUs;
      cfg_q.write_zero_low_us <= owbm_pkg::RstWriteZeroLowUs;
      cfg_q.read_low_us       <= owbm_pkg::RstReadLowUs;
      cfg_q.read_sample_us    <= owbm_pkg::RstReadSampleUs;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        owbm_pkg::CfgCyclesPerUs:    cfg_q.cycles_per_us     <= cfg_wdata_i[7:0];
        owbm_pkg::CfgResetLowUs:     cfg_q.reset_low_us      <= cfg_wdata_i;
        owbm_pkg::CfgPresenceWaitUs: cfg_q.presence_wait_us  <= cfg_wdata_i[7:0];
        owbm_pkg::CfgResetTailUs:    cfg_q.reset_tail_us     <= cfg_wdata_i;
        owbm_pkg::CfgWriteOneLowUs:  cfg_q.write_one_low_us  <= cfg_wdata_i[7:0];
        owbm_pkg::CfgWriteZeroLowUs: cfg_q.write_zero_low_us <= cfg_wdata_i[7:0];
        owbm_pkg::CfgReadLowUs:      cfg_q.read_low_us       <= cfg_wdata_i[7:0];
        owbm_pkg::CfgReadSampleUs:   cfg_q.read_sample_us    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Intake: accept ticks and decode the command kind
  owbm_front u_front (
    .in_if       (in_if),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Hold classified ticks until the engine takes them
  owbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  // Advance the bus timing one tick per popped beat
  owbm_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .tick_i  (pop_data),
    .empty_i (empty),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

FILE: rtl/core/owbm_front.sv
// ----------------------------------------------------------------------------
// owbm_front: tick intake and command decode
// Accept tick beats while the queue has room and classify the kind field.
// ----------------------------------------------------------------------------
module owbm_front (
  owbm_in_if.sink          in_if,
  input  logic             full_i,
  output logic             push_o,
  output owbm_pkg::tick_t  push_data_o
);

  owbm_pkg::cmd_e cmd;

  always_comb begin
    unique case (in_if.kind)
      owbm_pkg::CmdReset:    cmd = owbm_pkg::CmdReset;
      owbm_pkg::CmdWrite:    cmd = owbm_pkg::CmdWrite;
      owbm_pkg::CmdReadByte: cmd = owbm_pkg::CmdReadByte;
      owbm_pkg::CmdReadBit:  cmd = owbm_pkg::CmdReadBit;
      default:               cmd = owbm_pkg::CmdNone;  // drop unknown codes
    endcase
  end

  assign in_if.ready           = !full_i;
  assign push_o                = in_if.valid && !full_i;
  assign push_data_o.cmd       = cmd;
  assign push_data_o.tx_byte   = in_if.tx_byte;
  assign push_data_o.bus_level = in_if.bus_level;

endmodule

FILE: rtl/core/owbm_queue.sv
// ----------------------------------------------------------------------------
// owbm_queue: short FIFO of classified ticks
// Decouple the intake from the timing engine.
// ----------------------------------------------------------------------------
module owbm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  owbm_pkg::tick_t push_data_i,
  input  logic            pop_i,
  output owbm_pkg::tick_t pop_data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  owbm_pkg::tick_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/owbm_engine.sv
// ----------------------------------------------------------------------------
// owbm_engine: bus timing engine
// Advance the prescaler, phase timer and slot sequencer by one tick per beat
// and register the result beat.
// ----------------------------------------------------------------------------
module owbm_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  owbm_pkg::cfg_t  cfg_i,
  input  owbm_pkg::tick_t tick_i,
  input  logic            empty_i,
  output logic            pop_o,
  owbm_out_if.source      out_if
);

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhRstLow  = 4'd1,
    PhRstWait = 4'd2,
    PhRstTail = 4'd3,
    PhWrLow   = 4'd4,
    PhWrRel   = 4'd5,
    PhRdLow   = 4'd6,
    PhRdWait  = 4'd7,
    PhRdRest  = 4'd8
  } phase_e;

  localparam int unsigned UsW = owbm_pkg::UsW;

  phase_e                     phase_q, phase_d;
  owbm_pkg::cmd_e             op_q, op_d;
  logic [7:0]                 pre_q, pre_d;
  logic [UsW-1:0]             us_q, us_d;
  logic [2:0]                 bit_q, bit_d;
  logic [7:0]                 shift_q, shift_d;
  logic                       pres_q, pres_d;
  logic                       done;

  logic                       out_valid_q;
  logic                       drive_low_q, busy_q, done_q, presence_q;
  logic [7:0]                 rx_q;

  logic [7:0]                 cpu;
  logic [UsW-1:0]             plen;
  logic [UsW-1:0]             us_inc;
  logic [2:0]                 bit_inc;
  logic [7:0]                 raw8;

  function automatic logic [7:0] min_one8(input logic [7:0] v);
    return (v == '0) ? 8'd1 : v;
  endfunction

  function automatic logic [UsW-1:0] min_one10(input logic [UsW-1:0] v);
    return (v == '0) ? UsW'(1) : v;
  endfunction

  assign pop_o = !empty_i && (!out_valid_q || out_if.ready);
  assign cpu   = min_one8(cfg_i.cycles_per_us);

  // Length of the current phase in microseconds
  always_comb begin
    raw8 = '0;
    plen = owbm_pkg::ReadRestUs;
    unique case (phase_q)
      PhRstLow:  plen = min_one10(cfg_i.reset_low_us);
      PhRstWait: plen = {2'b00, min_one8(cfg_i.presence_wait_us)};
      PhRstTail: plen = min_one10(cfg_i.reset_tail_us);
      PhWrLow: begin
        raw8 = shift_q[0] ? cfg_i.write_one_low_us : cfg_i.write_zero_low_us;
        plen = {2'b00, min_one8(raw8)};
      end
      PhWrRel:   plen = shift_q[0] ? owbm_pkg::OneRelUs : owbm_pkg::ZeroRelUs;
      PhRdLow:   plen = {2'b00, min_one8(cfg_i.read_low_us)};
      PhRdWait:  plen = {2'b00, min_one8(cfg_i.read_sample_us)};
      default:   plen = owbm_pkg::ReadRestUs;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    pre_d   = pre_q;
    us_d    = us_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    done    = 1'b0;
    us_inc  = us_q + 1'b1;
    bit_inc = bit_q + 1'b1;

    if (phase_q == PhIdle) begin
      if (tick_i.cmd != owbm_pkg::CmdNone) begin
        op_d  = tick_i.cmd;
        pre_d = '0;
        us_d  = '0;
        bit_d = '0;
        unique case (tick_i.cmd)
          owbm_pkg::CmdReset: begin
            pres_d  = 1'b0;
            shift_d = '0;
            phase_d = PhRstLow;
          end
          owbm_pkg::CmdWrite: begin
            shift_d = tick_i.tx_byte;
            phase_d = PhWrLow;
          end
          default: begin
            shift_d = '0;
            phase_d = PhRdLow;
          end
        endcase
      end
    end else if ({1'b0, pre_q} + 9'd1 >= {1'b0, cpu}) begin
      pre_d = '0;
      if (us_inc >= plen) begin
        us_d = '0;
        unique case (phase_q)
          PhRstLow:  phase_d = PhRstWait;
          PhRstWait: begin
            pres_d  = !tick_i.bus_level;
            phase_d = PhRstTail;
          end
          PhRstTail: begin
            phase_d = PhIdle;
            done    = 1'b1;
          end
          PhWrLow:   phase_d = PhWrRel;
          PhRdLow:   phase_d = PhRdWait;
          PhRdWait: begin
            if (op_q == owbm_pkg::CmdReadBit) begin
              shift_d = {7'd0, tick_i.bus_level};
            end else begin
              shift_d = {tick_i.bus_level, shift_q[7:1]};
            end
            phase_d = PhRdRest;
          end
          PhWrRel, PhRdRest: begin
            if (phase_q == PhWrRel) begin
              shift_d = {1'b0, shift_q[7:1]};
            end
            // end of slot: finish after the last bit, else open the next slot
            if (op_q == owbm_pkg::CmdReadBit) begin
              phase_d = PhIdle;
              done    = 1'b1;
            end else begin
              bit_d = bit_inc;
              if (bit_inc == '0) begin
                phase_d = PhIdle;
                done    = 1'b1;
              end else begin
                phase_d = (op_q == owbm_pkg::CmdWrite) ? PhWrLow : PhRdLow;
              end
            end
          end
          default:   phase_d = PhIdle;
        endcase
      end else begin
        us_d = us_inc;
      end
    end else begin
      pre_d = pre_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      op_q        <= owbm_pkg::CmdNone;
      pre_q       <= '0;
      us_q        <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      pres_q      <= 1'b0;
      out_valid_q <= 1'b0;
      drive_low_q <= 1'b0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      presence_q  <= 1'b0;
      rx_q        <= '0;
    end else if (pop_o) begin
      phase_q     <= phase_d;
      op_q        <= op_d;
      pre_q       <= pre_d;
      us_q        <= us_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      pres_q      <= pres_d;
      out_valid_q <= 1'b1;
      drive_low_q <= (phase_d == PhRstLow) || (phase_d == PhWrLow) || (phase_d == PhRdLow);
      busy_q      <= (phase_d != PhIdle);
      done_q      <= done;
      presence_q  <= done && (op_d == owbm_pkg::CmdReset) && pres_d;
      rx_q        <= (done && ((op_d == owbm_pkg::CmdReadByte) ||
                               (op_d == owbm_pkg::CmdReadBit))) ? shift_d : 8'd0;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.drive_low = drive_low_q;
  assign out_if.busy_res  = busy_q;
  assign out_if.done_res  = done_q;
  assign out_if.presence  = presence_q;
  assign out_if.rx_data   = rx_q;

endmodule

FILE: rtl/core/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker: port-level assertions of the 1-Wire bus master
// Check result beat consistency and the result channel hold rule.
// ----------------------------------------------------------------------------
module owbm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       drive_low,
  input logic                       busy_res,
  input logic                       done_res,
  input logic                       presence,
  input logic [owbm_pkg::ByteW-1:0] rx_data
);

  // A finishing tick leaves the engine idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && done_res |-> !busy_res)
    else $error("done beat shows busy");

  // Pull the line low only during a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && drive_low |-> busy_res)
    else $error("line driven low while idle");

  // Presence and read data appear only on a done beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (presence || (rx_data != '0)) |-> done_res)
    else $error("presence or rx_data outside a done beat");

  // A busy beat that is not the last goes on as busy or finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && busy_res ##1 out_valid |-> busy_res || done_res)
    else $error("command ended without done");

  // A stalled result beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .drive_low (out_if.drive_low),
  .busy_res  (out_if.busy_res),
  .done_res  (out_if.done_res),
  .presence  (out_if.presence),
  .rx_data   (out_if.rx_data)
);

FILE: test/tb_one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master: self-checking bench for the timed 1-Wire master
// Feeds clock ticks (line level plus optional command) over the tick channel,
// predicts every result beat with a cycle-exact model of the bus timing
// engine, and compares each result beat field by field. A short table of
// directed commands comes first, zero registers among them, then random
// command traffic under a few short timing setups, each held to a tick budget.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;

  // Run limits and receiver hold-off
  localparam int unsigned CycleLimit    = 40_000;
  localparam int unsigned HoldOffAt     = 400;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned SettleCycles  = 6;

  // Kinds outside the command set; the block must treat them as no command
  localparam logic [owbm_pkg::KindW-1:0] KindRsvdA = 3'd5;
  localparam logic [owbm_pkg::KindW-1:0] KindRsvdB = 3'd6;
  localparam logic [owbm_pkg::KindW-1:0] KindRsvdC = 3'd7;

  // Bus phases of the timing engine, as the bench tracks them
  typedef enum logic [3:0] {
    PhIdle, PhRstLow, PhRstWait, PhRstTail, PhWrLow, PhWrRel, PhRdLow, PhRdWait, PhRdRest
  } bus_phase_e;

  typedef struct packed {
    logic                       drive_low;
    logic                       busy;
    logic                       done;
    logic                       presence;
    logic [owbm_pkg::ByteW-1:0] rx;
  } line_res_t;

  // Timing change applied before a directed row
  typedef enum logic [1:0] {TimingKeep, TimingShort, TimingZero} retime_e;

  typedef struct packed {
    retime_e                    retime;
    logic [owbm_pkg::KindW-1:0] kind;
    logic [owbm_pkg::ByteW-1:0] tx;
    logic                       level;
    logic                       run_out;  // keep ticking until the command finishes
    logic                       typed;    // use the hand-written result below
    line_res_t                  want;
  } dir_row_t;

  localparam line_res_t ResIdle    = '0;
  localparam line_res_t ResOpening = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00};

  // Short slots so a command takes few ticks
  localparam owbm_pkg::cfg_t ShortSetup = '{8'd1, 10'd3, 8'd2, 10'd2, 8'd1, 8'd2, 8'd1, 8'd1};
  // All registers zero: every register duration and the prescaler fall back to one
  localparam owbm_pkg::cfg_t ZeroSetup  = '0;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [owbm_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [owbm_pkg::CfgW-1:0]      cfg_wdata_i;

  owbm_in_if  in_if();
  owbm_out_if out_if();

  one_wire_bus_master DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Timing engine prediction: state, timing registers, one step per tick
  // --------------------------------------------------------------------------
  owbm_pkg::cfg_t timing = '{owbm_pkg::RstCyclesPerUs, owbm_pkg::RstResetLowUs,
                             owbm_pkg::RstPresenceWaitUs, owbm_pkg::RstResetTailUs,
                             owbm_pkg::RstWriteOneLowUs, owbm_pkg::RstWriteZeroLowUs,
                             owbm_pkg::RstReadLowUs, owbm_pkg::RstReadSampleUs};

  bus_phase_e                 ph        = PhIdle;
  owbm_pkg::cmd_e             op        = owbm_pkg::CmdNone;
  logic [7:0]                 presc     = '0;
  logic [owbm_pkg::UsW-1:0]   us_cnt    = '0;
  logic [2:0]                 bit_idx   = '0;
  logic [owbm_pkg::ByteW-1:0] shreg     = '0;
  logic                       pres_flag = 1'b0;

  line_res_t   line_expect_q[$];
  line_res_t   line_seen_q[$];
  int unsigned mismatches  = 0;
  int unsigned beats_taken = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;

  // A zero register counts as one
  function automatic int unsigned at_least_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // Length in microseconds of the phase the engine is in
  function automatic int unsigned phase_us();
    case (ph)
      PhRstLow:  return at_least_one(timing.reset_low_us);
      PhRstWait: return at_least_one(timing.presence_wait_us);
      PhRstTail: return at_least_one(timing.reset_tail_us);
      PhWrLow:   return at_least_one(shreg[0] ? timing.write_one_low_us
                                              : timing.write_zero_low_us);
      PhWrRel:   return shreg[0] ? owbm_pkg::OneRelUs : owbm_pkg::ZeroRelUs;
      PhRdLow:   return at_least_one(timing.read_low_us);
      PhRdWait:  return at_least_one(timing.read_sample_us);
      default:   return owbm_pkg::ReadRestUs;
    endcase
  endfunction

  // Ticks a command takes from its opening tick to its done tick
  function automatic int unsigned cmd_ticks(logic [owbm_pkg::KindW-1:0] kind,
                                            logic [owbm_pkg::ByteW-1:0] tx);
    int unsigned us;
    us = 0;
    case (kind)
      owbm_pkg::CmdReset: begin
        us = at_least_one(timing.reset_low_us) + at_least_one(timing.presence_wait_us) +
             at_least_one(timing.reset_tail_us);
      end
      owbm_pkg::CmdWrite: begin
        for (int b = 0; b < owbm_pkg::ByteW; b++) begin
          us += tx[b] ? at_least_one(timing.write_one_low_us) + owbm_pkg::OneRelUs
                      : at_least_one(timing.write_zero_low_us) + owbm_pkg::ZeroRelUs;
        end
      end
      owbm_pkg::CmdReadByte: begin
        us = owbm_pkg::ByteW * (at_least_one(timing.read_low_us) +
             at_least_one(timing.read_sample_us) + owbm_pkg::ReadRestUs);
      end
      owbm_pkg::CmdReadBit: begin
        us = at_least_one(timing.read_low_us) + at_least_one(timing.read_sample_us) +
             owbm_pkg::ReadRestUs;
      end
      default: us = 0;
    endcase
    return 1 + us * at_least_one(timing.cycles_per_us);
  endfunction

  // Close a bit slot: advance to the next bit, or finish the command
  function automatic logic slot_over();
    logic fin;
    if (op == owbm_pkg::CmdReadBit) begin
      fin = 1'b1;
    end else begin
      bit_idx = bit_idx + 3'd1;
      fin = (bit_idx == 3'd0);
    end
    if (fin) begin
      ph = PhIdle;
    end else if (op == owbm_pkg::CmdWrite) begin
      ph = PhWrLow;
    end else begin
      ph = PhRdLow;
    end
    return fin;
  endfunction

  // Move on from a phase whose time ran out; samples use this tick's level
  function automatic logic phase_over(logic level);
    logic fin;
    fin = 1'b0;
    case (ph)
      PhRstLow:  ph = PhRstWait;
      PhRstWait: begin
        pres_flag = ~level;
        ph = PhRstTail;
      end
      PhRstTail: begin
        ph = PhIdle;
        fin = 1'b1;
      end
      PhWrLow:   ph = PhWrRel;
      PhWrRel:   begin
        shreg = shreg >> 1;
        fin = slot_over();
      end
      PhRdLow:   ph = PhRdWait;
      PhRdWait:  begin
        if (op == owbm_pkg::CmdReadBit) begin
          shreg = {{(owbm_pkg::ByteW-1){1'b0}}, level};
        end else begin
          shreg = {level, shreg[owbm_pkg::ByteW-1:1]};
        end
        ph = PhRdRest;
      end
      PhRdRest:  fin = slot_over();
      default:   ph = PhIdle;
    endcase
    return fin;
  endfunction

  // One tick of the engine; returns the result beat it must produce
  function automatic line_res_t engine_tick(logic [owbm_pkg::KindW-1:0] kind,
                                            logic [owbm_pkg::ByteW-1:0] tx, logic level);
    line_res_t r;
    logic      fin;
    fin = 1'b0;
    if (ph == PhIdle) begin
      // only an idle engine takes a command; spare kinds fall through
      if (kind >= owbm_pkg::CmdReset && kind <= owbm_pkg::CmdReadBit) begin
        op      = owbm_pkg::cmd_e'(kind);
        presc   = '0;
        us_cnt  = '0;
        bit_idx = '0;
        if (op == owbm_pkg::CmdReset) begin
          pres_flag = 1'b0;
          shreg     = '0;
          ph        = PhRstLow;
        end else if (op == owbm_pkg::CmdWrite) begin
          shreg = tx;
          ph    = PhWrLow;
        end else begin
          shreg = '0;
          ph    = PhRdLow;
        end
      end
    end else if (32'(presc) + 1 >= at_least_one(timing.cycles_per_us)) begin
      presc  = '0;
      us_cnt = us_cnt + 1'b1;
      if (us_cnt >= phase_us()) begin
        us_cnt = '0;
        fin = phase_over(level);
      end
    end else begin
      presc = presc + 8'd1;
    end
    r.drive_low = (ph == PhRstLow) || (ph == PhWrLow) || (ph == PhRdLow);
    r.busy      = (ph != PhIdle);
    r.done      = fin;
    r.presence  = (fin && op == owbm_pkg::CmdReset) ? pres_flag : 1'b0;
    r.rx        = (fin && (op == owbm_pkg::CmdReadByte || op == owbm_pkg::CmdReadBit))
                  ? shreg : '0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tick sender: offer one beat, hold it until taken, then record the
  // predicted result. Bursts of random length alternate with random gaps.
  // Enter and leave at a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_tick(logic [owbm_pkg::KindW-1:0] kind, logic [owbm_pkg::ByteW-1:0] tx,
                           logic level, logic typed = 1'b0, line_res_t want = '0);
    line_res_t pred;
    in_if.valid     = 1'b1;
    in_if.kind      = kind;
    in_if.tx_byte   = tx;
    in_if.bus_level = level;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pred = engine_tick(kind, tx, level);
    line_expect_q.push_back(typed ? want : pred);
    @(negedge clk_i);
    if (burst_left == 0) begin
      // drop valid for a while, then pick the next burst; some run long
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Tick the engine back to idle, drop valid and let every result drain
  task automatic quiesce();
    while (ph != PhIdle) begin
      send_tick(owbm_pkg::CmdNone, 8'($urandom), 1'($urandom_range(0, 1)));
    end
    in_if.valid = 1'b0;
    while (line_expect_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write all timing registers in index order on an idle block
  task automatic load_timing(owbm_pkg::cfg_t t);
    owbm_pkg::cfg_idx_e idx;
    quiesce();
    idx = idx.first();
    cfg_we_i = 1'b1;
    repeat (idx.num()) begin
      cfg_idx_i = idx;
      case (idx)
        owbm_pkg::CfgCyclesPerUs:    cfg_wdata_i = owbm_pkg::CfgW'(t.cycles_per_us);
        owbm_pkg::CfgResetLowUs:     cfg_wdata_i = owbm_pkg::CfgW'(t.reset_low_us);
        owbm_pkg::CfgPresenceWaitUs: cfg_wdata_i = owbm_pkg::CfgW'(t.presence_wait_us);
        owbm_pkg::CfgResetTailUs:    cfg_wdata_i = owbm_pkg::CfgW'(t.reset_tail_us);
        owbm_pkg::CfgWriteOneLowUs:  cfg_wdata_i = owbm_pkg::CfgW'(t.write_one_low_us);
        owbm_pkg::CfgWriteZeroLowUs: cfg_wdata_i = owbm_pkg::CfgW'(t.write_zero_low_us);
        owbm_pkg::CfgReadLowUs:      cfg_wdata_i = owbm_pkg::CfgW'(t.read_low_us);
        default:                     cfg_wdata_i = owbm_pkg::CfgW'(t.read_sample_us);
      endcase
      @(negedge clk_i);
      idx = idx.next();
    end
    cfg_we_i = 1'b0;
    timing = t;
  endtask

  // Random short timing: register durations of one to top microseconds
  function automatic owbm_pkg::cfg_t small_timing(int unsigned cpu, int unsigned top);
    owbm_pkg::cfg_t t;
    t.cycles_per_us     = 8'(cpu);
    t.reset_low_us      = owbm_pkg::UsW'($urandom_range(1, top));
    t.presence_wait_us  = 8'($urandom_range(1, top));
    t.reset_tail_us     = owbm_pkg::UsW'($urandom_range(1, top));
    t.write_one_low_us  = 8'($urandom_range(1, top));
    t.write_zero_low_us = 8'($urandom_range(1, top));
    t.read_low_us       = 8'($urandom_range(1, top));
    t.read_sample_us    = 8'($urandom_range(1, top));
    return t;
  endfunction

  // Pick a command; the cheap mix keeps to reset and read bit
  function automatic logic [owbm_pkg::KindW-1:0] pick_cmd(logic cheap);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (cheap) return (roll < 10) ? owbm_pkg::CmdReset : owbm_pkg::CmdReadBit;
    if (roll < 6)  return owbm_pkg::CmdReset;
    if (roll < 11) return owbm_pkg::CmdWrite;
    if (roll < 14) return owbm_pkg::CmdReadByte;
    return owbm_pkg::CmdReadBit;
  endfunction

  // Random traffic for about the given number of ticks. An idle engine only
  // gets a command that finishes inside the budget. Commands keep coming
  // while busy, so some land on the finishing tick.
  task automatic run_random(int unsigned budget, logic cheap);
    int unsigned                sent;
    int unsigned                roll;
    logic [owbm_pkg::KindW-1:0] kind;
    logic [owbm_pkg::ByteW-1:0] tx;
    sent = 0;
    while (sent < budget || ph != PhIdle) begin
      roll = $urandom_range(0, 19);
      tx   = 8'($urandom);
      if (ph == PhIdle) begin
        if (roll < 5) begin
          kind = owbm_pkg::CmdNone;
        end else if (roll == 5) begin
          kind = owbm_pkg::KindW'($urandom_range(KindRsvdA, KindRsvdC));
        end else begin
          kind = pick_cmd(cheap);
        end
        if (sent + cmd_ticks(kind, tx) > budget) kind = owbm_pkg::CmdNone;
      end else begin
        kind = (roll < 12) ? owbm_pkg::CmdNone
                           : owbm_pkg::KindW'($urandom_range(owbm_pkg::CmdReset,
                                                             owbm_pkg::CmdReadBit));
      end
      send_tick(kind, tx, 1'($urandom_range(0, 1)));
      sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: stall on a pattern that changes mode every stretch, and
  // once hold off long enough that the queue fills and tick ready drops.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned mode;
    int unsigned span;
    int unsigned step;
    logic        held_off;
    held_off = 1'b0;
    step = 0;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk_i);
        step++;
        if (!held_off && beats_taken >= HoldOffAt) begin
          held_off = 1'b1;
          out_if.ready = 1'b0;
          repeat (HoldOffCycles) @(negedge clk_i);
        end else begin
          case (mode)
            0:       out_if.ready = 1'b1;
            1:       out_if.ready = ($urandom_range(0, 3) != 0);
            2:       out_if.ready = ((step % 4) != 3);
            default: out_if.ready = 1'($urandom_range(0, 1));
          endcase
        end
      end
    end
  end

  // Capture each result beat at the rising edge; compare it at the falling
  // edge, once every expectation pushed at that rising edge is in place
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      line_seen_q.push_back(line_res_t'{out_if.drive_low, out_if.busy_res, out_if.done_res,
                                        out_if.presence, out_if.rx_data});
      beats_taken++;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin : result_check
    line_res_t got;
    line_res_t want;
    if (line_seen_q.size() != 0) begin
      got = line_seen_q.pop_front();
      if (line_expect_q.size() == 0) begin
        $error("result beat with no tick waiting for it");
        mismatches++;
      end else begin
        want = line_expect_q.pop_front();
        check_field("drive_low", want.drive_low, got.drive_low);
        check_field("busy_res",  want.busy,      got.busy);
        check_field("done_res",  want.done,      got.done);
        check_field("presence",  want.presence,  got.presence);
        check_field("rx_data",   want.rx,        got.rx);
      end
    end
  end

  // Watchdog over the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed table, then random phases under short timing setups
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t       dir_rows [13];
    owbm_pkg::cfg_t t;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = owbm_pkg::CfgCyclesPerUs;
    cfg_wdata_i     = '0;
    in_if.valid     = 1'b0;
    in_if.kind      = owbm_pkg::CmdNone;
    in_if.tx_byte   = '0;
    in_if.bus_level = 1'b1;

    dir_rows = '{
      // short timing: idle tick, spare kind ignored
      '{TimingShort, owbm_pkg::CmdNone,     8'h00, 1'b1, 1'b0, 1'b1, ResIdle},
      '{TimingKeep,  KindRsvdC,             8'hFF, 1'b1, 1'b0, 1'b1, ResIdle},
      // presence seen and missed
      '{TimingKeep,  owbm_pkg::CmdReset,    8'h00, 1'b0, 1'b1, 1'b1, ResOpening},
      '{TimingKeep,  owbm_pkg::CmdReset,    8'h00, 1'b1, 1'b1, 1'b0, ResIdle},
      // write a byte of all zeros
      '{TimingKeep,  owbm_pkg::CmdWrite,    8'h00, 1'b1, 1'b1, 1'b1, ResOpening},
      // commands offered while busy are dropped; the read bit sees a low line
      '{TimingKeep,  owbm_pkg::CmdReadBit,  8'h00, 1'b1, 1'b0, 1'b0, ResIdle},
      '{TimingKeep,  owbm_pkg::CmdWrite,    8'h3C, 1'b1, 1'b0, 1'b0, ResIdle},
      '{TimingKeep,  owbm_pkg::CmdReset,    8'h00, 1'b0, 1'b1, 1'b0, ResIdle},
      '{TimingKeep,  KindRsvdA,             8'h55, 1'b0, 1'b0, 1'b1, ResIdle},
      '{TimingKeep,  KindRsvdB,             8'hAA, 1'b1, 1'b0, 1'b1, ResIdle},
      // zero registers: prescaler and every register duration act as one
      '{TimingZero,  owbm_pkg::CmdReset,    8'h00, 1'b0, 1'b1, 1'b1, ResOpening},
      '{TimingKeep,  owbm_pkg::CmdWrite,    8'h01, 1'b1, 1'b1, 1'b0, ResIdle},
      '{TimingKeep,  owbm_pkg::CmdReadByte, 8'h00, 1'b1, 1'b1, 1'b0, ResIdle}
    };

    // hold reset, then release it away from the rising edge
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].retime == TimingShort) load_timing(ShortSetup);
      if (dir_rows[i].retime == TimingZero)  load_timing(ZeroSetup);
      send_tick(dir_rows[i].kind, dir_rows[i].tx, dir_rows[i].level,
                dir_rows[i].typed, dir_rows[i].want);
      // hold the row's line level until the command is through
      if (dir_rows[i].run_out) begin
        while (ph != PhIdle) send_tick(owbm_pkg::CmdNone, 8'($urandom), dir_rows[i].level);
      end
    end

    for (int p = 0; p < 3; p++) begin
      case (p)
        0:       t = small_timing(1, 3);
        // slower prescale, short durations
        1:       t = small_timing(3, 2);
        default: t = small_timing(1, 1);
      endcase
      load_timing(t);
      case (p)
        0:       run_random(120, 1'b0);
        1:       run_random(150, 1'b1);
        default: run_random(50, 1'b0);
      endcase
    end

    quiesce();
    if (mismatches == 0 && line_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
